FILE: hdl/rcfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC channel frame encoder package
// Shared widths, register map, byte constants and the CRC-8 step.
// ----------------------------------------------------------------------------
package rcfe_pkg;

  localparam int unsigned ChanW  = 11;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 4;

  localparam logic [ByteW-1:0] SyncHi   = 8'hFF;
  localparam logic [ByteW-1:0] SyncLo   = 8'h00;
  localparam logic [ByteW-1:0] LenByte  = 8'd24;
  localparam logic [ByteW-1:0] CrcPoly  = 8'hD5;
  localparam logic [3:0]       LastChan = 4'd15;

  localparam logic [ByteW-1:0] DestAddrRst = 8'd200;
  localparam logic [ByteW-1:0] FrameTypeRst = 8'd22;
  localparam logic             PreambleRst  = 1'b1;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    RegDestAddr  = 2'd0,
    RegFrameType = 2'd1,
    RegPreamble  = 2'd2,
    RegUnused    = 2'd3
  } reg_idx_e;

  // Kind of byte at one slot of a request's output run
  typedef enum logic [1:0] {
    KindHdr  = 2'd0,
    KindType = 2'd1,
    KindPay  = 2'd2,
    KindCrc  = 2'd3
  } kind_e;

  // One CRC-8 step over a byte, MSB first, no reflection, no final xor
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                    input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rcfe_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC channel frame encoder input channel
// Valid/ready channel carrying one channel value per request.
// ----------------------------------------------------------------------------
interface rcfe_in_if import rcfe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] channel_value;

  modport source (output valid, output channel_value, input ready);
  modport sink   (input valid, input channel_value, output ready);
endinterface
`default_nettype wire

FILE: hdl/rcfe_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC channel frame encoder output channel
// Valid/ready channel carrying one frame byte per request.
// ----------------------------------------------------------------------------
interface rcfe_out_if import rcfe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             run_last;
  logic             frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/rc_channel_frame_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC channel frame encoder
// Packs 11-bit channel values into RC channel frames with a trailing CRC-8.
// ----------------------------------------------------------------------------
// Each input request carries one channel value; sixteen requests make a frame.
// The first channel of a frame emits the optional sync preamble FF 00 FF 00,
// then the address, the length byte 24 and the frame type. Every channel adds
// one or two packed payload bytes (LSB first, contiguous), and the sixteenth
// closes the frame with the CRC-8 byte (poly 0xD5, init 0, over type and
// payload), flagged by frame_end. run_last marks the final byte of each
// request. Output runs at one byte per cycle while the sink takes each byte;
// a request yields 1 to 8 bytes, and a full 30-byte frame (with preamble)
// carries 16 requests. The next request is taken in the cycle the last byte
// of the current one moves into the output register; out_o.ready reaches
// in_i.ready combinationally, so output back-pressure stalls the input.
// The user must write registers over the APB port only while the block is
// idle (not enforced by the block); writes take effect at the next frame.
// ----------------------------------------------------------------------------
module rc_channel_frame_encoder_top
  import rcfe_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  rcfe_in_if.sink               in_i,
  rcfe_out_if.source            out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ByteW-1:0] dest_addr_q;
  logic [ByteW-1:0] frame_type_q;
  logic             pre_en_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_addr_q  <= DestAddrRst;
      frame_type_q <= FrameTypeRst;
      pre_en_q     <= PreambleRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegDestAddr:  dest_addr_q  <= pwdata[ByteW-1:0];
        RegFrameType: frame_type_q <= pwdata[ByteW-1:0];
        RegPreamble:  pre_en_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegDestAddr:  prdata = {{(DataW-ByteW){1'b0}}, dest_addr_q};
      RegFrameType: prdata = {{(DataW-ByteW){1'b0}}, frame_type_q};
      RegPreamble:  prdata = {{(DataW-1){1'b0}}, pre_en_q};
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Packing state, advanced once per accepted request
  // --------------------------------------------------------------------------
  logic [3:0] pos_q,  pos_d;
  logic [6:0] pend_q, pend_d;
  logic [2:0] pcnt_q, pcnt_d;

  // Byte issue stage: describes the run of bytes for the request in flight
  logic             a_vld_q, a_vld_d;
  logic [2:0]       cur_q,   cur_d;     // slot being issued
  logic [2:0]       last_q,  last_d;    // last slot of the run
  logic [2:0]       hbase_q, hbase_d;   // first header byte index
  logic [2:0]       hnum_q,  hnum_d;    // number of header bytes
  logic [1:0]       pnum_q,  pnum_d;    // number of payload bytes
  logic [ByteW-1:0] pay0_q, pay0_d;
  logic [ByteW-1:0] pay1_q, pay1_d;

  logic [ByteW-1:0] crc_q, crc_d;

  // Output register
  logic             ov_q, ov_d;
  logic [ByteW-1:0] ob_q, ob_d;
  logic             ol_q, ol_d;
  logic             oe_q, oe_d;

  logic             load;      // move one byte into the output register
  logic             run_done;  // the byte moved is the last of its run
  logic             accept;

  assign load     = a_vld_q && (!ov_q || out_o.ready);
  assign run_done = load && (cur_q == last_q);
  assign in_i.ready = !a_vld_q || run_done;
  assign accept   = in_i.valid && in_i.ready;

  // --------------------------------------------------------------------------
  // Request decode: header layout and payload bytes
  // --------------------------------------------------------------------------
  logic        first_ch;
  logic [6:0]  eff_pend;
  logic [2:0]  eff_cnt;
  logic [17:0] acc;
  logic [4:0]  total;
  logic        two_bytes;
  logic [2:0]  hnum_new;
  logic [3:0]  run_len;

  always_comb begin
    first_ch  = (pos_q == '0);
    eff_pend  = first_ch ? '0 : pend_q;
    eff_cnt   = first_ch ? '0 : pcnt_q;
    acc       = ({7'd0, in_i.channel_value} << eff_cnt) | {11'd0, eff_pend};
    total     = {2'd0, eff_cnt} + 5'(ChanW);
    two_bytes = (total >= 5'd16);
    hnum_new  = first_ch ? (pre_en_q ? 3'd7 : 3'd3) : 3'd0;
    run_len   = {1'b0, hnum_new} + (two_bytes ? 4'd2 : 4'd1)
              + ((pos_q == LastChan) ? 4'd1 : 4'd0);
  end

  // --------------------------------------------------------------------------
  // Slot decode for the byte being issued
  // --------------------------------------------------------------------------
  kind_e            kind;
  logic [2:0]       pslot;
  logic [2:0]       hidx;
  logic [ByteW-1:0] sel_byte;

  always_comb begin
    pslot = cur_q - hnum_q;
    hidx  = hbase_q + cur_q;
    if (cur_q < hnum_q) begin
      kind = (hidx == 3'd6) ? KindType : KindHdr;
    end else if (pslot < {1'b0, pnum_q}) begin
      kind = KindPay;
    end else begin
      kind = KindCrc;
    end

    case (kind)
      KindHdr: begin
        case (hidx)
          3'd0:    sel_byte = SyncHi;
          3'd1:    sel_byte = SyncLo;
          3'd2:    sel_byte = SyncHi;
          3'd3:    sel_byte = SyncLo;
          3'd4:    sel_byte = dest_addr_q;
          3'd5:    sel_byte = LenByte;
          default: sel_byte = frame_type_q;
        endcase
      end
      KindType: sel_byte = frame_type_q;
      KindPay:  sel_byte = (pslot == 3'd0) ? pay0_q : pay1_q;
      KindCrc:  sel_byte = crc_q;
      default:  sel_byte = crc_q;
    endcase
  end

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    pos_d    = pos_q;
    pend_d   = pend_q;
    pcnt_d   = pcnt_q;
    a_vld_d  = a_vld_q;
    cur_d    = cur_q;
    last_d   = last_q;
    hbase_d  = hbase_q;
    hnum_d   = hnum_q;
    pnum_d   = pnum_q;
    pay0_d   = pay0_q;
    pay1_d   = pay1_q;
    crc_d    = crc_q;
    ov_d     = ov_q;
    ob_d     = ob_q;
    ol_d     = ol_q;
    oe_d     = oe_q;

    // Drain the output register when the sink takes it
    if (out_o.ready) begin
      ov_d = 1'b0;
    end

    // Issue one byte of the current run
    if (load) begin
      ov_d = 1'b1;
      ob_d = sel_byte;
      ol_d = (cur_q == last_q);
      oe_d = (kind == KindCrc);
      case (kind)
        KindType: crc_d = crc8_update('0, frame_type_q);
        KindPay:  crc_d = crc8_update(crc_q, sel_byte);
        default:  crc_d = crc_q;
      endcase
      if (run_done) begin
        a_vld_d = 1'b0;
      end else begin
        cur_d = cur_q + 3'd1;
      end
    end

    // Take a new request and lay out its run
    if (accept) begin
      a_vld_d  = 1'b1;
      cur_d    = '0;
      last_d   = 3'(run_len - 4'd1);
      hbase_d  = pre_en_q ? 3'd0 : 3'd4;
      hnum_d   = hnum_new;
      pnum_d   = two_bytes ? 2'd2 : 2'd1;
      pay0_d   = acc[7:0];
      pay1_d   = acc[15:8];
      if (two_bytes) begin
        pend_d = {5'd0, acc[17:16]};
        pcnt_d = 3'(total - 5'd16);
      end else begin
        pend_d = acc[14:8];
        pcnt_d = 3'(total - 5'd8);
      end
      // Close the frame: clear leftovers, position wraps to zero
      if (pos_q == LastChan) begin
        pend_d = '0;
        pcnt_d = '0;
      end
      pos_d = pos_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pend_q  <= '0;
      pcnt_q  <= '0;
      crc_q   <= '0;
      a_vld_q <= 1'b0;
      cur_q   <= '0;
      last_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      pcnt_q  <= pcnt_d;
      crc_q   <= crc_d;
      a_vld_q <= a_vld_d;
      cur_q   <= cur_d;
      last_q  <= last_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    hbase_q  <= hbase_d;
    hnum_q   <= hnum_d;
    pnum_q   <= pnum_d;
    pay0_q   <= pay0_d;
    pay1_q   <= pay1_d;
    ob_q     <= ob_d;
    ol_q     <= ol_d;
    oe_q     <= oe_d;
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_byte  = ob_q;
  assign out_o.run_last  = ol_q;
  assign out_o.frame_end = oe_q;

endmodule
`default_nettype wire
